/* hw/rtl/bmpu_pkg.sv */
// shared types and constants for the bmp pixel stream unpacker
package bmpu_pkg;

  localparam int unsigned SCREEN_ROWS    = 480;
  localparam int unsigned SCREEN_COLUMNS = 800;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned ORG_W      = 10;
  localparam int unsigned COORD_W    = 12;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_PRESENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_DOWN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_COLUMNS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COLUMN  = 3'd6;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd800;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

  // byte position inside a pixel
  localparam logic [1:0] BYTE_BLUE  = 2'd0;
  localparam logic [1:0] BYTE_GREEN = 2'd1;
  localparam logic [1:0] BYTE_RED   = 2'd2;
  localparam logic [1:0] BYTE_ALPHA = 2'd3;

  localparam logic [COORD_W-1:0] SCREEN_ROWS_C    = COORD_W'(SCREEN_ROWS);
  localparam logic [COORD_W-1:0] SCREEN_COLUMNS_C = COORD_W'(SCREEN_COLUMNS);

  typedef struct packed {
    logic             alpha_present;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             top_down;
    logic             mirror_columns;
    logic [ORG_W-1:0] origin_row;
    logic [ORG_W-1:0] origin_column;
  } cfg_t;

endpackage

/* hw/rtl/bmp_pixel_stream_unpacker.sv */
// top level of the bmp pixel stream unpacker
// Takes the BMP pixel array one byte per transfer (row padding included) and
// emits one result transfer per completed pixel: a 32-bit ARGB color plus an
// unclipped 12-bit two's complement screen row and column, with last_pixel set
// on the final pixel of the image, after which the counters restart. Bytes are
// blue, green, red and, when alpha_present is set, alpha; alpha reads zero in
// 24-bit mode. Padding to a 4-byte row boundary is skipped without output.
// Every byte is handled in the cycle it is accepted: counters and the color
// merge update at the input transfer and the result lands in the output
// register, so one byte is taken per clock as long as the output side keeps
// up. The input stalls only while the output register holds a result that
// the receiver is stalling. Configuration is written through
// cfg_we/cfg_index/cfg_wdata while the block is idle (the user's duty; the
// block does not enforce it); indexes beyond the register list are ignored.
module bmp_pixel_stream_unpacker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [bmpu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bmpu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  // byte input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_data_byte,
  // pixel output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bmpu_pkg::COORD_W-1:0]  out_screen_row,
  output logic signed [bmpu_pkg::COORD_W-1:0]  out_screen_column,
  output logic [31:0]                          out_pixel_color,
  output logic                                 out_last_pixel
);

  // configuration registers
  bmpu_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_present  <= 1'b0;
      cfg_r.image_width    <= bmpu_pkg::WIDTH_RESET;
      cfg_r.image_height   <= bmpu_pkg::HEIGHT_RESET;
      cfg_r.top_down       <= 1'b0;
      cfg_r.mirror_columns <= 1'b0;
      cfg_r.origin_row     <= '0;
      cfg_r.origin_column  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmpu_pkg::REG_ALPHA_PRESENT:  cfg_r.alpha_present  <= cfg_wdata[0];
        bmpu_pkg::REG_IMAGE_WIDTH:    cfg_r.image_width    <= cfg_wdata;
        bmpu_pkg::REG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_wdata;
        bmpu_pkg::REG_TOP_DOWN:       cfg_r.top_down       <= cfg_wdata[0];
        bmpu_pkg::REG_MIRROR_COLUMNS: cfg_r.mirror_columns <= cfg_wdata[0];
        bmpu_pkg::REG_ORIGIN_ROW:     cfg_r.origin_row     <= cfg_wdata[bmpu_pkg::ORG_W-1:0];
        bmpu_pkg::REG_ORIGIN_COLUMN:  cfg_r.origin_column  <= cfg_wdata[bmpu_pkg::ORG_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // unpacking state
  logic [1:0]                 byte_in_pixel_r, byte_in_pixel_nxt;
  logic [23:0]                partial_color_r, partial_color_nxt;
  logic [bmpu_pkg::DIM_W-1:0] column_count_r, column_count_nxt;
  logic [bmpu_pkg::DIM_W-1:0] row_count_r, row_count_nxt;
  logic [1:0]                 pad_remaining_r, pad_remaining_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  logic [bmpu_pkg::COORD_W-1:0] row_r, row_nxt;
  logic [bmpu_pkg::COORD_W-1:0] col_r, col_nxt;
  logic [31:0]                  color_r, color_nxt;
  logic                         last_r, last_nxt;

  logic in_xfer;
  logic out_xfer;
  logic emit;
  logic row_end;
  logic img_end;
  logic [31:0] emit_color;
  logic [bmpu_pkg::COORD_W-1:0] col_ext, rowc_ext, org_r_ext, org_c_ext;

  // stall only while a finished pixel is being held by the receiver
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  assign col_ext   = {1'b0, column_count_r};
  assign rowc_ext  = {1'b0, row_count_r};
  assign org_r_ext = {2'b00, cfg_r.origin_row};
  assign org_c_ext = {2'b00, cfg_r.origin_column};

  // a zero width or height behaves like one
  assign row_end = (col_ext + 12'd1) >= {1'b0, cfg_r.image_width};
  assign img_end = row_end && ((rowc_ext + 12'd1) >= {1'b0, cfg_r.image_height});

  // fourth byte is alpha whenever it is pending, even if the mode changed since
  assign emit_color = (byte_in_pixel_r == bmpu_pkg::BYTE_ALPHA)
                    ? {in_data_byte, partial_color_r}
                    : {8'h00, in_data_byte, partial_color_r[15:0]};

  always_comb begin
    byte_in_pixel_nxt = byte_in_pixel_r;
    partial_color_nxt = partial_color_r;
    column_count_nxt  = column_count_r;
    row_count_nxt     = row_count_r;
    pad_remaining_nxt = pad_remaining_r;
    emit              = 1'b0;

    if (in_xfer) begin
      if (pad_remaining_r != 2'd0) begin
        pad_remaining_nxt = pad_remaining_r - 2'd1;
      end else begin
        unique case (byte_in_pixel_r)
          bmpu_pkg::BYTE_BLUE: begin
            partial_color_nxt = {16'h0000, in_data_byte};
            byte_in_pixel_nxt = bmpu_pkg::BYTE_GREEN;
          end
          bmpu_pkg::BYTE_GREEN: begin
            partial_color_nxt = {8'h00, in_data_byte, partial_color_r[7:0]};
            byte_in_pixel_nxt = bmpu_pkg::BYTE_RED;
          end
          bmpu_pkg::BYTE_RED: begin
            if (cfg_r.alpha_present) begin
              partial_color_nxt = {in_data_byte, partial_color_r[15:0]};
              byte_in_pixel_nxt = bmpu_pkg::BYTE_ALPHA;
            end else begin
              emit = 1'b1;
            end
          end
          bmpu_pkg::BYTE_ALPHA: emit = 1'b1;
          default: ;
        endcase
      end
    end

    if (emit) begin
      byte_in_pixel_nxt = bmpu_pkg::BYTE_BLUE;
      partial_color_nxt = '0;
      if (row_end) begin
        column_count_nxt  = '0;
        // pad to 4 bytes: -(3*w) mod 4 equals w mod 4
        pad_remaining_nxt = cfg_r.alpha_present ? 2'd0 : cfg_r.image_width[1:0];
        row_count_nxt     = img_end ? '0 : row_count_r + 11'd1;
      end else begin
        column_count_nxt  = column_count_r + 11'd1;
      end
    end
  end

  // screen coordinates, modulo 4096
  always_comb begin
    if (cfg_r.top_down) begin
      row_nxt = rowc_ext + org_r_ext;
    end else begin
      row_nxt = bmpu_pkg::SCREEN_ROWS_C - rowc_ext - 12'd1 - org_r_ext;
    end
    if (cfg_r.mirror_columns) begin
      col_nxt = bmpu_pkg::SCREEN_COLUMNS_C - col_ext - 12'd1 - org_c_ext;
    end else begin
      col_nxt = col_ext + org_c_ext;
    end
    color_nxt     = emit_color;
    last_nxt      = img_end;
    out_valid_nxt = emit ? 1'b1 : (out_xfer ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_pixel_r <= bmpu_pkg::BYTE_BLUE;
      partial_color_r <= '0;
      column_count_r  <= '0;
      row_count_r     <= '0;
      pad_remaining_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      byte_in_pixel_r <= byte_in_pixel_nxt;
      partial_color_r <= partial_color_nxt;
      column_count_r  <= column_count_nxt;
      row_count_r     <= row_count_nxt;
      pad_remaining_r <= pad_remaining_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // result payload, loaded only when a pixel completes
  always_ff @(posedge clk) begin
    if (emit) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      color_r <= color_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_screen_row    = row_r;
  assign out_screen_column = col_r;
  assign out_pixel_color   = color_r;
  assign out_last_pixel    = last_r;

endmodule

/* hw/rtl/bmpu_checker.sv */
// port-level checks for the bmp pixel stream unpacker, bound to the top level
module bmpu_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [bmpu_pkg::COORD_W-1:0] out_screen_row,
  input logic signed [bmpu_pkg::COORD_W-1:0] out_screen_column,
  input logic [31:0]                         out_pixel_color,
  input logic                                out_last_pixel
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_screen_row)
      && $stable(out_screen_column) && $stable(out_pixel_color)
      && $stable(out_last_pixel))
    else $error("stalled result changed");

  // input is only held back by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // a new result only follows an input transfer
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input transfer");

endmodule

bind bmp_pixel_stream_unpacker bmpu_checker u_bmpu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_screen_row    (out_screen_row),
  .out_screen_column (out_screen_column),
  .out_pixel_color   (out_pixel_color),
  .out_last_pixel    (out_last_pixel)
);
